FILE: rtl/affine_footprint_mask_engine_unit_assert.svh
// Assertion macros for the affine footprint mask engine.
`ifndef AFFINE_FOOTPRINT_MASK_ENGINE_UNIT_ASSERT_SVH
`define AFFINE_FOOTPRINT_MASK_ENGINE_UNIT_ASSERT_SVH
// Same-cycle implication, checked out of reset.
`define AFME_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define AFME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/afme_pkg.sv
// Shared types, constants and helpers for the affine footprint mask engine.
package afme_pkg;

  localparam int MASK_WIDTH  = 52;
  localparam int MASK_HEIGHT = 44;
  localparam int FULL_WIDTH  = 104;
  localparam int FULL_HEIGHT = 88;
  localparam int FIX_ONE     = 256;

  localparam int COEF_W = 32;
  localparam int CNT_W  = 14;
  localparam int PCT_W  = 7;
  localparam int IDX_W  = 7;
  localparam int BIT_W  = IDX_W + 3;

  // Packed half-resolution map
  localparam int MAP_W    = MASK_WIDTH / 2;
  localparam int MAP_H    = MASK_HEIGHT / 2;
  localparam int MAP_BITS = MAP_W * MAP_H;
  localparam logic [BIT_W-1:0] LRECIP = BIT_W'((1 << BIT_W) / MAP_W);

  // Grid walk counters cover the larger grid
  localparam int GRID_W_MAX = (FULL_WIDTH > MASK_WIDTH) ? FULL_WIDTH : MASK_WIDTH;
  localparam int GRID_H_MAX = (FULL_HEIGHT > MASK_HEIGHT) ? FULL_HEIGHT : MASK_HEIGHT;
  localparam int XW     = $clog2(GRID_W_MAX);
  localparam int YW     = $clog2(GRID_H_MAX);
  localparam int ROW_AW = $clog2(MASK_HEIGHT);
  localparam int COL_W  = $clog2(MASK_WIDTH);

  // Affine accumulators hold the exact image
  localparam int ACC_W = COEF_W + XW + YW + 2;
  localparam logic signed [ACC_W-1:0] MASK_BX = ACC_W'((MASK_WIDTH - 1) * FIX_ONE);
  localparam logic signed [ACC_W-1:0] MASK_BY = ACC_W'((MASK_HEIGHT - 1) * FIX_ONE);
  localparam logic signed [ACC_W-1:0] FULL_BX = ACC_W'((FULL_WIDTH - 1) * FIX_ONE);
  localparam logic signed [ACC_W-1:0] FULL_BY = ACC_W'((FULL_HEIGHT - 1) * FIX_ONE);

  // Percent by reciprocal multiply with one correction
  localparam int MASK_CELLS = MASK_WIDTH * MASK_HEIGHT;
  localparam int PCT_SCALE  = 100;
  localparam int PROD_W     = $clog2(MASK_CELLS * PCT_SCALE + 1);
  localparam logic [PROD_W-1:0] PRECIP = PROD_W'((1 << PROD_W) / MASK_CELLS);

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_REMOVE = 2'd1,
    FN_AREA   = 2'd2,
    FN_FULL   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LDIV1,
    ST_LDIV2,
    ST_LREAD,
    ST_LWRITE,
    ST_RREAD,
    ST_CELLS,
    ST_RWRITE,
    ST_PCT1,
    ST_PCT2,
    ST_PCT3,
    ST_DONE
  } state_t;

  // Walk control from sequencer to affine unit
  typedef struct packed {
    logic start;
    logic step;
    logic next_row;
    logic full;
  } afme_walk_t;

  function automatic logic signed [ACC_W-1:0] sext_coef(input logic [COEF_W-1:0] v);
    return {{(ACC_W - COEF_W){v[COEF_W-1]}}, v};
  endfunction

endpackage

FILE: rtl/afme_affine.sv
// Incremental affine image of the walked grid point and its bounds test.
module afme_affine import afme_pkg::*; (
  input  logic              clk,
  input  afme_walk_t        walk,
  input  logic [COEF_W-1:0] scale_xx,
  input  logic [COEF_W-1:0] scale_xy,
  input  logic [COEF_W-1:0] offset_x,
  input  logic [COEF_W-1:0] scale_yx,
  input  logic [COEF_W-1:0] scale_yy,
  input  logic [COEF_W-1:0] offset_y,
  output logic              in_b
);

  logic signed [ACC_W-1:0] cxx, cxy, cyx, cyy;
  logic signed [ACC_W-1:0] mx, my, mx_row, my_row;
  logic                    full_r;
  logic signed [ACC_W-1:0] bx, by;

  // Coefficient latch and running sums
  always_ff @(posedge clk) begin
    if (walk.start) begin
      cxx    <= sext_coef(scale_xx);
      cxy    <= sext_coef(scale_xy);
      cyx    <= sext_coef(scale_yx);
      cyy    <= sext_coef(scale_yy);
      mx     <= sext_coef(offset_x);
      my     <= sext_coef(offset_y);
      mx_row <= sext_coef(offset_x);
      my_row <= sext_coef(offset_y);
      full_r <= walk.full;
    end else if (walk.next_row) begin
      mx_row <= mx_row + cxy;
      my_row <= my_row + cyy;
      mx     <= mx_row + cxy;
      my     <= my_row + cyy;
    end else if (walk.step) begin
      mx <= mx + cxx;
      my <= my + cyx;
    end
  end

  // Bounds of the grid being walked
  always_comb begin
    bx   = full_r ? FULL_BX : MASK_BX;
    by   = full_r ? FULL_BY : MASK_BY;
    in_b = !mx[ACC_W-1] && (mx <= bx) && !my[ACC_W-1] && (my <= by);
  end

endmodule

FILE: rtl/affine_footprint_mask_engine_unit.sv
// Load: two divide states locate the first map bit of the byte, then
//   for each map bit both its mask rows are read and written, up to the map end.
// Remove: one cell per cycle, and one read and one write of a mask row on the
//   single memory port. Area: mask grid walk, then percent; full area: full grid.
// One transaction at a time; the next is taken once the result is registered.
// Reset clears control and output valid; the mask memory is not cleared.
`include "affine_footprint_mask_engine_unit_assert.svh"
module affine_footprint_mask_engine_unit import afme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [IDX_W-1:0]  byte_index,
  input  logic [7:0]        byte_value,
  input  logic [COEF_W-1:0] scale_xx,
  input  logic [COEF_W-1:0] scale_xy,
  input  logic [COEF_W-1:0] offset_x,
  input  logic [COEF_W-1:0] scale_yx,
  input  logic [COEF_W-1:0] scale_yy,
  input  logic [COEF_W-1:0] offset_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  cell_count,
  output logic [PCT_W-1:0]  percent
);

  state_t state, state_next;
  func_t  func_r;

  logic [BIT_W-1:0]  bit_pos, ld_q, map_x, map_y;
  logic [7:0]        bval;
  logic [2:0]        bcnt;
  logic              sub;
  logic [XW-1:0]     x;
  logic [YW-1:0]     y;
  logic [CNT_W-1:0]  count;
  logic [MASK_WIDTH-1:0] clr;
  logic [PROD_W-1:0] pct_prod, pct_q;

  // Mask memory, one row per entry
  logic [MASK_WIDTH-1:0] mem [MASK_HEIGHT];
  logic [MASK_WIDTH-1:0] rdata, mem_wdata, ld_mask;
  logic [ROW_AW-1:0]     mem_addr;
  logic                  mem_we, mem_re;

  afme_walk_t walk;
  logic       in_b, full_sel, last_x, last_y, hit, accept, out_free;
  logic [2*BIT_W-1:0]  ld_prod;
  logic [BIT_W-1:0]    ld_rem;
  logic [2*PROD_W-1:0] pct_mul;
  logic [PROD_W-1:0]   pct_rem;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  afme_affine u_affine (
    .clk      (clk),
    .walk     (walk),
    .scale_xx (scale_xx),
    .scale_xy (scale_xy),
    .offset_x (offset_x),
    .scale_yx (scale_yx),
    .scale_yy (scale_yy),
    .offset_y (offset_y),
    .in_b     (in_b)
  );

  // Grid walk and load helpers
  always_comb begin
    full_sel = (func_r == FN_FULL);
    last_x   = full_sel ? (x == XW'(FULL_WIDTH - 1)) : (x == XW'(MASK_WIDTH - 1));
    last_y   = full_sel ? (y == YW'(FULL_HEIGHT - 1)) : (y == YW'(MASK_HEIGHT - 1));
    hit      = in_b && ((func_r != FN_REMOVE) || rdata[x[COL_W-1:0]]);
    ld_prod  = bit_pos * LRECIP;
    ld_rem   = bit_pos - BIT_W'(ld_q * BIT_W'(MAP_W));
    ld_mask  = MASK_WIDTH'(2'b11) << {map_x, 1'b0};
    pct_mul  = pct_prod * PRECIP;
    pct_rem  = pct_prod - PROD_W'(pct_q * PROD_W'(MASK_CELLS));
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory access and walk control
  always_comb begin
    state_next    = state;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = ROW_AW'(y);
    mem_wdata     = rdata & ~clr;
    walk.start    = 1'b0;
    walk.step     = 1'b0;
    walk.next_row = 1'b0;
    walk.full     = (func_t'(func) == FN_FULL);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          walk.start = 1'b1;
          unique case (func_t'(func))
            FN_LOAD:   state_next = ST_LDIV1;
            FN_REMOVE: state_next = ST_RREAD;
            default:   state_next = ST_CELLS;
          endcase
        end
      end
      ST_LDIV1: state_next = ST_LDIV2;
      ST_LDIV2: state_next = ST_LREAD;
      ST_LREAD: begin
        mem_addr = ROW_AW'({map_y, sub});
        if (int'(bit_pos) >= MAP_BITS) begin
          state_next = ST_DONE;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_LWRITE;
        end
      end
      ST_LWRITE: begin
        mem_addr  = ROW_AW'({map_y, sub});
        mem_we    = 1'b1;
        mem_wdata = (rdata & ~ld_mask) | (bval[bcnt] ? ld_mask : '0);
        state_next = (sub && bcnt == 3'd7) ? ST_DONE : ST_LREAD;
      end
      ST_RREAD: begin
        mem_re     = 1'b1;
        state_next = ST_CELLS;
      end
      ST_CELLS: begin
        if (!last_x) begin
          walk.step = 1'b1;
        end else if (func_r == FN_REMOVE) begin
          state_next = ST_RWRITE;
        end else if (last_y) begin
          state_next = (func_r == FN_AREA) ? ST_PCT1 : ST_DONE;
        end else begin
          walk.next_row = 1'b1;
        end
      end
      ST_RWRITE: begin
        mem_we        = 1'b1;
        walk.next_row = 1'b1;
        state_next    = last_y ? ST_DONE : ST_RREAD;
      end
      ST_PCT1: state_next = ST_PCT2;
      ST_PCT2: state_next = ST_PCT3;
      ST_PCT3: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Mask memory port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          func_r  <= func_t'(func);
          bit_pos <= {byte_index, 3'b000};
          bval    <= byte_value;
          bcnt    <= '0;
          sub     <= 1'b0;
          x       <= '0;
          y       <= '0;
          count   <= '0;
          pct_q   <= '0;
        end
      end
      ST_LDIV1: ld_q <= ld_prod[2*BIT_W-1:BIT_W];
      ST_LDIV2: begin
        if (ld_rem >= BIT_W'(MAP_W)) begin
          map_x <= ld_rem - BIT_W'(MAP_W);
          map_y <= ld_q + 1'b1;
        end else begin
          map_x <= ld_rem;
          map_y <= ld_q;
        end
      end
      ST_LWRITE: begin
        sub <= !sub;
        if (sub) begin
          bcnt    <= bcnt + 1'b1;
          bit_pos <= bit_pos + 1'b1;
          if (map_x == BIT_W'(MAP_W - 1)) begin
            map_x <= '0;
            map_y <= map_y + 1'b1;
          end else begin
            map_x <= map_x + 1'b1;
          end
        end
      end
      ST_RREAD: clr <= '0;
      ST_CELLS: begin
        if (hit) count <= count + 1'b1;
        if (hit && func_r == FN_REMOVE) clr[x[COL_W-1:0]] <= 1'b1;
        if (last_x && func_r != FN_REMOVE && !last_y) begin
          x <= '0;
          y <= y + 1'b1;
        end else if (!last_x) begin
          x <= x + 1'b1;
        end
      end
      ST_RWRITE: begin
        x <= '0;
        y <= y + 1'b1;
      end
      ST_PCT1: pct_prod <= PROD_W'(count * PROD_W'(PCT_SCALE));
      ST_PCT2: pct_q <= pct_mul[2*PROD_W-1:PROD_W];
      ST_PCT3: begin
        if (pct_rem >= PROD_W'(MASK_CELLS)) pct_q <= pct_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      cell_count <= (func_r == FN_LOAD) ? '0 : count;
      percent    <= (func_r == FN_AREA) ? PCT_W'(pct_q) : '0;
    end
  end

  `AFME_ASSERT_NEXT(a_busy_after_accept, accept, state != ST_IDLE, "accept left engine idle")
  `AFME_ASSERT_IMPL(a_we_states, mem_we, state == ST_LWRITE || state == ST_RWRITE, "stray write")
  `AFME_ASSERT_IMPL(a_rwrite_remove, state == ST_RWRITE, func_r == FN_REMOVE, "row write not remove")
  `AFME_ASSERT_IMPL(a_stall_busy, state != ST_IDLE, in_stall, "input taken while busy")

endmodule

FILE: dv/afme_scoreboard.sv
// Checker for the affine footprint mask engine: predicts and compares results.
`timescale 1ns / 100ps
module afme_scoreboard import afme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        func,
  input  logic [IDX_W-1:0]  byte_index,
  input  logic [7:0]        byte_value,
  input  logic [COEF_W-1:0] scale_xx,
  input  logic [COEF_W-1:0] scale_xy,
  input  logic [COEF_W-1:0] offset_x,
  input  logic [COEF_W-1:0] scale_yx,
  input  logic [COEF_W-1:0] scale_yy,
  input  logic [COEF_W-1:0] offset_y,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CNT_W-1:0]  cell_count,
  input  logic [PCT_W-1:0]  percent,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);

  // Shadow copy of the coverage mask
  logic [MASK_WIDTH-1:0] shadow_mask [MASK_HEIGHT];
  logic [CNT_W-1:0] count_q [$];
  logic [PCT_W-1:0] pct_q [$];
  int n_accepted;

  // True when the image of (x,y) lies inside a w x h grid
  function automatic bit lands_inside(input longint t[6], input int x, input int y,
                                      input int w, input int h);
    longint mx, my;
    mx = t[0] * x + t[1] * y + t[2];
    my = t[3] * x + t[4] * y + t[5];
    return mx >= 0 && mx <= longint'(w - 1) * FIX_ONE &&
           my >= 0 && my <= longint'(h - 1) * FIX_ONE;
  endfunction

  // Apply one transaction to the shadow mask and queue its expected result
  task automatic predict_mask_op();
    longint t[6];
    int unsigned cnt, bitpos, px, py;
    logic [PCT_W-1:0] pct;
    t[0] = longint'(signed'(scale_xx));
    t[1] = longint'(signed'(scale_xy));
    t[2] = longint'(signed'(offset_x));
    t[3] = longint'(signed'(scale_yx));
    t[4] = longint'(signed'(scale_yy));
    t[5] = longint'(signed'(offset_y));
    cnt = 0;
    pct = '0;
    case (func_t'(func))
      FN_LOAD: begin
        for (int b = 0; b < 8; b++) begin
          bitpos = byte_index * 8 + b;
          if (bitpos < MAP_BITS) begin
            py = bitpos / MAP_W;
            px = bitpos % MAP_W;
            shadow_mask[2*py][2*px]       = byte_value[b];
            shadow_mask[2*py][2*px+1]     = byte_value[b];
            shadow_mask[2*py+1][2*px]     = byte_value[b];
            shadow_mask[2*py+1][2*px+1]   = byte_value[b];
          end
        end
      end
      FN_REMOVE: begin
        for (int y = 0; y < MASK_HEIGHT; y++)
          for (int x = 0; x < MASK_WIDTH; x++)
            if (shadow_mask[y][x] === 1'b1 &&
                lands_inside(t, x, y, MASK_WIDTH, MASK_HEIGHT)) begin
              shadow_mask[y][x] = 1'b0;
              cnt++;
            end
      end
      FN_AREA: begin
        for (int y = 0; y < MASK_HEIGHT; y++)
          for (int x = 0; x < MASK_WIDTH; x++)
            if (lands_inside(t, x, y, MASK_WIDTH, MASK_HEIGHT)) cnt++;
        pct = PCT_W'(cnt * PCT_SCALE / MASK_CELLS);
      end
      default: begin
        for (int y = 0; y < FULL_HEIGHT; y++)
          for (int x = 0; x < FULL_WIDTH; x++)
            if (lands_inside(t, x, y, FULL_WIDTH, FULL_HEIGHT)) cnt++;
      end
    endcase
    count_q.push_back(CNT_W'(cnt));
    pct_q.push_back(pct);
  endtask

  assign pending = n_accepted - results_seen;

  initial begin
    fail_count = 0;
    results_seen = 0;
    n_accepted = 0;
    for (int y = 0; y < MASK_HEIGHT; y++) shadow_mask[y] = '0;
  end

  // Watch both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_mask_op();
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (count_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: cell_count=%0d percent=%0d", cell_count, percent);
          fail_count++;
        end else begin
          if (cell_count !== count_q[0] || percent !== pct_q[0]) begin
            if (fail_count < 10)
              $display("mismatch #%0d: cell_count exp %0d got %0d, percent exp %0d got %0d",
                       results_seen, count_q[0], cell_count, pct_q[0], percent);
            fail_count++;
          end
          void'(count_q.pop_front());
          void'(pct_q.pop_front());
        end
        results_seen++;
      end
    end
  end

endmodule

FILE: dv/tb_affine_footprint_mask_engine_unit.sv
// Testbench top: stimulus, handshake pressure and verdict for the mask engine.
`timescale 1ns / 100ps
module tb_affine_footprint_mask_engine_unit;
  import afme_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        func;
  logic [IDX_W-1:0]  byte_index;
  logic [7:0]        byte_value;
  logic [COEF_W-1:0] scale_xx, scale_xy, offset_x, scale_yx, scale_yy, offset_y;
  logic              out_valid;
  logic              out_stall;
  logic [CNT_W-1:0]  cell_count;
  logic [PCT_W-1:0]  percent;
  int                fail_count, pending, results_seen;
  bit                quiet = 1'b0;

  localparam logic [31:0] ONE   = 32'h0000_0100;
  localparam logic [31:0] ZERO  = 32'h0;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG1  = 32'hFFFF_FFFF;
  localparam int NUM_BYTES = (MAP_BITS + 7) / 8;

  always #2 clk = ~clk;

  affine_footprint_mask_engine_unit dut (.*);

  afme_scoreboard checker_i (.*);

  // Scale near unity in most cases, anything at all sometimes
  function automatic logic [31:0] pick_scale();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 768)) - 32'd384;
  endfunction

  function automatic logic [31:0] pick_offset();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 64 * 256)) - 32'd2048;
  endfunction

  // Offer one transaction and hold it until taken
  task automatic issue(input func_t f, input logic [6:0] idx, input logic [7:0] val,
                       input logic [31:0] c0, input logic [31:0] c1, input logic [31:0] c2,
                       input logic [31:0] c3, input logic [31:0] c4, input logic [31:0] c5);
    func <= f; byte_index <= idx; byte_value <= val;
    scale_xx <= c0; scale_xy <= c1; offset_x <= c2;
    scale_yx <= c3; scale_yy <= c4; offset_y <= c5;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic issue_grid(input func_t f);
    issue(f, 7'($urandom), 8'($urandom), pick_scale(), pick_scale(), pick_offset(),
          pick_scale(), pick_scale(), pick_offset());
  endtask

  // Receiver side: random stall bursts plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 30) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    int r;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FN_LOAD; byte_index <= '0; byte_value <= '0;
    scale_xx <= '0; scale_xy <= '0; offset_x <= '0;
    scale_yx <= '0; scale_yy <= '0; offset_y <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // grid counts at the coefficient extremes
    issue(FN_AREA, 0, 0, ONE, ZERO, ZERO, ZERO, ONE, ZERO);
    issue(FN_FULL, 0, 0, ONE, ZERO, ZERO, ZERO, ONE, ZERO);
    issue(FN_AREA, 0, 0, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
    issue(FN_AREA, 0, 0, ONE, ZERO, NEG1, ZERO, ONE, ZERO);
    issue(FN_AREA, 0, 0, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN);
    issue(FN_FULL, 0, 0, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX);
    issue(FN_AREA, 0, 0, 32'h80, ZERO, ZERO, ZERO, 32'h80, 32'd5120);
    issue(FN_FULL, 0, 0, NEG1, ZERO, 32'd26368, ZERO, NEG1, 32'd22272);

    // fill the whole map, first bytes solid and empty, rest random
    for (int i = 0; i < NUM_BYTES; i++)
      issue(FN_LOAD, 7'(i), (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom),
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    // bytes past the map are ignored, as are the bits of the last byte past its end
    issue(FN_LOAD, 7'd72, 8'hFF, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
    issue(FN_LOAD, 7'd127, 8'hFF, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
    issue(FN_LOAD, 7'd71, 8'hFF, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO);
    issue(FN_REMOVE, 0, 0, ONE, ZERO, 32'd2560, ZERO, ONE, ZERO);
    issue(FN_REMOVE, 0, 0, ONE, ZERO, ZERO, ZERO, ONE, ZERO);
    issue(FN_REMOVE, 0, 0, ONE, ZERO, ZERO, ZERO, ONE, ZERO);

    // sender holds back until the block has drained
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    // random part: loads interleaved with footprint and area work
    for (int n = 0; n < 175; n++) begin
      if (n == 150) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 45)
        issue(FN_LOAD, ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 71)),
              8'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 65) issue_grid(FN_REMOVE);
      else if (r < 85) issue_grid(FN_AREA);
      else issue_grid(FN_FULL);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog
  initial begin
    #48ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: affine_footprint_mask_engine_unit.f
+incdir+rtl
rtl/afme_pkg.sv
rtl/afme_affine.sv
rtl/affine_footprint_mask_engine_unit.sv
dv/afme_scoreboard.sv
dv/tb_affine_footprint_mask_engine_unit.sv
